/* src/dpcm_audio_chunk_decoder_defines.svh */
// assertion macros for the dpcm audio chunk decoder checker
// no dependencies; included by the checker file only
`ifndef DPCM_AUDIO_CHUNK_DECODER_DEFINES_SVH
`define DPCM_AUDIO_CHUNK_DECODER_DEFINES_SVH

// property checked at every edge outside reset
`define DACD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property checked at every edge, reset included
`define DACD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

/* src/dacd_pkg.sv */
// shared types and constants of the dpcm audio chunk decoder
// no dependencies
package dacd_pkg;

   localparam int BYTE_W   = 8;
   localparam int ID_W     = 16;
   localparam int OFFS_W   = 10;
   localparam int LEVEL_W  = 16;
   localparam int PWM_W    = 11;
   localparam int FRAMES_W = 16;
   localparam int SHIFT    = 6;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MONO_ID       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_ID     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_OFFSET = 2'd2;

   localparam logic [ID_W-1:0]   MONO_ID_RST       = 16'd4128;
   localparam logic [ID_W-1:0]   STEREO_ID_RST     = 16'd4129;
   localparam logic [OFFS_W-1:0] OUTPUT_OFFSET_RST = 10'd2;

   typedef enum logic [2:0] {
      PH_HUNT_A,
      PH_HUNT_B,
      PH_HUNT_C,
      PH_LENGTH,
      PH_LEVELS,
      PH_SAMPLES
   } phase_type;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_INIT_MONO,
      OP_INIT_STEREO
   } op_type;

   // front to back command; data holds the sample byte in its low byte
   // or the two level bytes {second, first}
   typedef struct packed {
      op_type              op;
      logic [LEVEL_W-1:0]  data;
      logic                chan;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic [PWM_W-1:0] pwm;
      logic             chan;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* src/dacd_queue.sv */
// small first-in first-out queue of packed beats
// depends on dacd_pkg for the status struct
module dacd_queue
   import dacd_pkg::*;
#(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] din,
   input  logic             pop,
   output logic [Width-1:0] dout,
   output q_status_type     status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             wr, rd;

   assign status.full  = (count_ff == CntW'(Depth));
   assign status.empty = (count_ff == '0);
   assign wr   = push & ~status.full;
   assign rd   = pop & ~status.empty;
   assign dout = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

/* src/dacd_front.sv */
// stream parser: id hunt, length and level header, sample classification
// depends on dacd_pkg
module dacd_front
   import dacd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              beat,
   input  logic [BYTE_W-1:0] stream_byte,
   input  logic [ID_W-1:0]   mono_id,
   input  logic [ID_W-1:0]   stereo_id,
   output logic              cmd_push,
   output cmd_type           cmd
);

   phase_type            phase_ff, phase_in;
   logic [15:0]          held_ff, held_in;
   logic [1:0]           count_ff, count_in;
   logic [FRAMES_W-1:0]  frames_ff, frames_in;
   logic                 stereo_ff, stereo_in;
   logic                 right_ff, right_in;

   logic [ID_W-1:0]      cand;
   logic                 hit_mono, hit_stereo, hit;
   logic [FRAMES_W-1:0]  len_val;
   logic [FRAMES_W-1:0]  frames_dec;
   logic                 frames_done;

   always_comb begin
      cand = (phase_ff == PH_HUNT_C) ? {stream_byte, held_ff[15:8]}
                                     : {stream_byte, held_ff[7:0]};
   end

   assign hit_mono    = (cand == mono_id);
   assign hit_stereo  = (cand == stereo_id);
   assign hit         = hit_mono | hit_stereo;
   assign frames_dec  = frames_ff - 1'b1;
   assign frames_done = (frames_dec == '0);

   // length byte folded into the count, saturating on the upper bytes
   always_comb begin
      unique case (count_ff)
         2'd0:    len_val = {8'h00, stream_byte};
         2'd1:    len_val = {stream_byte, frames_ff[7:0]};
         default: len_val = (stream_byte != '0) ? '1 : frames_ff;
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (beat) begin
         unique case (phase_ff)
            PH_HUNT_B:  phase_in = hit ? PH_LENGTH : PH_HUNT_C;
            PH_HUNT_C:  phase_in = hit ? PH_LENGTH : PH_HUNT_A;
            PH_LENGTH:  phase_in = (count_ff == 2'd3) ? PH_LEVELS : PH_LENGTH;
            PH_LEVELS: begin
               if (count_ff != '0) begin
                  phase_in = (frames_ff != '0) ? PH_SAMPLES : PH_HUNT_A;
               end
            end
            PH_SAMPLES: begin
               if ((!stereo_ff || right_ff) && frames_done) begin
                  phase_in = PH_HUNT_A;
               end
            end
            default:    phase_in = PH_HUNT_B;
         endcase
      end
   end

   // datapath and command outputs
   always_comb begin
      held_in   = held_ff;
      count_in  = count_ff;
      frames_in = frames_ff;
      stereo_in = stereo_ff;
      right_in  = right_ff;
      cmd_push  = 1'b0;
      cmd.op    = OP_SAMPLE;
      cmd.data  = {8'h00, stream_byte};
      cmd.chan  = 1'b0;
      cmd.last  = 1'b0;
      if (beat) begin
         unique case (phase_ff) inside
            PH_HUNT_B, PH_HUNT_C: begin
               if (hit) begin
                  stereo_in = ~hit_mono;
                  count_in  = '0;
               end else if (phase_ff == PH_HUNT_B) begin
                  held_in = {stream_byte, held_ff[7:0]};
               end
            end
            PH_LENGTH: begin
               frames_in = len_val;
               if (count_ff == 2'd3) begin
                  if (stereo_ff) begin
                     frames_in = len_val >> 1;
                  end
                  count_in = '0;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PH_LEVELS: begin
               if (count_ff == '0) begin
                  held_in  = {8'h00, stream_byte};
                  count_in = 2'd1;
               end else begin
                  cmd_push = 1'b1;
                  cmd.op   = stereo_ff ? OP_INIT_STEREO : OP_INIT_MONO;
                  cmd.data = {stream_byte, held_ff[7:0]};
                  right_in = 1'b0;
                  count_in = '0;
               end
            end
            PH_SAMPLES: begin
               cmd_push = 1'b1;
               if (stereo_ff && right_ff) begin
                  cmd.chan  = 1'b1;
                  right_in  = 1'b0;
                  frames_in = frames_dec;
                  cmd.last  = frames_done;
               end else if (stereo_ff) begin
                  right_in = 1'b1;
               end else begin
                  frames_in = frames_dec;
                  cmd.last  = frames_done;
               end
            end
            default: held_in = {8'h00, stream_byte};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT_A;
         held_ff   <= '0;
         count_ff  <= '0;
         frames_ff <= '0;
         stereo_ff <= 1'b0;
         right_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         count_ff  <= count_in;
         frames_ff <= frames_in;
         stereo_ff <= stereo_in;
         right_ff  <= right_in;
      end
   end

endmodule

/* src/dacd_back.sv */
// channel levels: square-law delta, clamp, scaling to the output code
// depends on dacd_pkg
module dacd_back
   import dacd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_take,
   input  logic              out_full,
   input  logic [OFFS_W-1:0] output_offset,
   output logic              out_push,
   output rsp_type           out_rsp
);

   logic [LEVEL_W-1:0] left_ff, left_in;
   logic [LEVEL_W-1:0] right_ff, right_in;
   logic [LEVEL_W-1:0] level_old, level_new;
   logic [6:0]         mag;
   logic [13:0]        sq;
   logic [LEVEL_W:0]   sum;
   logic               is_sample;

   assign is_sample = (cmd.op == OP_SAMPLE);
   assign cmd_take  = cmd_valid & (~is_sample | ~out_full);
   assign out_push  = cmd_take & is_sample;

   assign level_old = cmd.chan ? right_ff : left_ff;
   assign mag       = cmd.data[6:0];
   assign sq        = mag * mag;
   assign sum       = {1'b0, level_old} + {3'b000, sq};

   always_comb begin
      if (cmd.data[7]) begin
         level_new = (level_old >= {2'b00, sq}) ? level_old - {2'b00, sq} : '0;
      end else begin
         level_new = sum[LEVEL_W] ? '1 : sum[LEVEL_W-1:0];
      end
   end

   assign out_rsp.pwm  = {1'b0, output_offset} + PWM_W'(level_new >> SHIFT);
   assign out_rsp.chan = cmd.chan;
   assign out_rsp.last = cmd.last;

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      if (cmd_take) begin
         unique case (cmd.op)
            OP_SAMPLE: begin
               if (cmd.chan) begin
                  right_in = level_new;
               end else begin
                  left_in = level_new;
               end
            end
            OP_INIT_MONO:   left_in = cmd.data ^ 16'h8000;
            OP_INIT_STEREO: begin
               left_in  = {cmd.data[15:8] ^ 8'h80, 8'h00};
               right_in = {cmd.data[7:0] ^ 8'h80, 8'h00};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= '0;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

endmodule

/* src/dpcm_audio_chunk_decoder.sv */
// a sample beat passes the command queue and then the result queue, both registered, before it shows on the rsp ports
// throughput: one stream byte per cycle while full is low, set by the combinational square,
// add and clamp path in the level unit; full rises only when the command queue fills
// header bytes give no result; they only pass level set-up through the queue
// reset is synchronous: queues empty, parser hunting, registers at defaults
module dpcm_audio_chunk_decoder
   import dacd_pkg::*;
#(
   parameter int MidDepth = MID_DEPTH,
   parameter int OutDepth = OUT_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // input stream
   input  logic                 push,
   output logic                 full,
   input  logic [BYTE_W-1:0]    req_stream_byte,
   // results
   output logic                 empty,
   input  logic                 pop,
   output logic [PWM_W-1:0]     rsp_pwm_sample,
   output logic                 rsp_channel,
   output logic                 rsp_chunk_end,
   // configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ID_W-1:0]      csr_wdata
);

   // configuration registers
   logic [ID_W-1:0]   mono_id_ff, mono_id_in;
   logic [ID_W-1:0]   stereo_id_ff, stereo_id_in;
   logic [OFFS_W-1:0] offset_ff, offset_in;

   // front to back
   logic          beat;
   logic          front_push;
   cmd_type       front_cmd;
   cmd_type       mid_head;
   q_status_type  mid_status;
   logic          back_take;

   // back to result queue
   logic          back_push;
   rsp_type       back_rsp;
   rsp_type       out_head;
   q_status_type  out_status;

   // register writes, unknown indexes are dropped
   always_comb begin
      mono_id_in   = mono_id_ff;
      stereo_id_in = stereo_id_ff;
      offset_in    = offset_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MONO_ID:       mono_id_in   = csr_wdata;
            CSR_STEREO_ID:     stereo_id_in = csr_wdata;
            CSR_OUTPUT_OFFSET: offset_in    = csr_wdata[OFFS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mono_id_ff   <= MONO_ID_RST;
         stereo_id_ff <= STEREO_ID_RST;
         offset_ff    <= OUTPUT_OFFSET_RST;
      end else begin
         mono_id_ff   <= mono_id_in;
         stereo_id_ff <= stereo_id_in;
         offset_ff    <= offset_in;
      end
   end

   // a beat is taken whenever the command queue has room, even if
   // the byte turns out to be header that pushes nothing
   assign full = mid_status.full;
   assign beat = push & ~full;

   dacd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .stream_byte (req_stream_byte),
      .mono_id     (mono_id_ff),
      .stereo_id   (stereo_id_ff),
      .cmd_push    (front_push),
      .cmd         (front_cmd)
   );

   // decouples parsing from level arithmetic and result back-pressure
   dacd_queue #(
      .Width (($bits(cmd_type))),
      .Depth (MidDepth)
   ) u_mid_q (
      .clock  (clock),
      .reset  (reset),
      .push   (front_push),
      .din    (front_cmd),
      .pop    (back_take),
      .dout   (mid_head),
      .status (mid_status)
   );

   // level init commands drain even while the result queue is full
   dacd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (~mid_status.empty),
      .cmd           (mid_head),
      .cmd_take      (back_take),
      .out_full      (out_status.full),
      .output_offset (offset_ff),
      .out_push      (back_push),
      .out_rsp       (back_rsp)
   );

   // result queue parts the level unit from the consumer
   dacd_queue #(
      .Width (($bits(rsp_type))),
      .Depth (OutDepth)
   ) u_out_q (
      .clock  (clock),
      .reset  (reset),
      .push   (back_push),
      .din    (back_rsp),
      .pop    (pop),
      .dout   (out_head),
      .status (out_status)
   );

   assign empty          = out_status.empty;
   assign rsp_pwm_sample = out_head.pwm;
   assign rsp_channel    = out_head.chan;
   assign rsp_chunk_end  = out_head.last;

endmodule

/* src/dacd_checker.sv */
// port-level checks for the dpcm audio chunk decoder, bound to the top level
// depends on dpcm_audio_chunk_decoder_defines.svh
`include "dpcm_audio_chunk_decoder_defines.svh"

module dacd_checker (
   input logic        clock,
   input logic        reset,
   input logic        push,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [10:0] rsp_pwm_sample,
   input logic        rsp_channel,
   input logic        rsp_chunk_end
);

   // both queues come out of reset drained
   `DACD_ASSERT_ALWAYS(a_reset_drained, clock, reset |=> (empty && !full), "queues not drained after reset")

   // a waiting result beat holds until it is popped
   `DACD_ASSERT(a_rsp_hold, clock, reset, (!empty && !pop) |=> (!empty && $stable(rsp_pwm_sample) && $stable(rsp_channel) && $stable(rsp_chunk_end)), "waiting result changed")

   // the command queue only fills from an input beat
   `DACD_ASSERT(a_full_from_push, clock, reset, $rose(full) |-> $past(push), "full rose without a push")

endmodule

bind dpcm_audio_chunk_decoder dacd_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .push           (push),
   .full           (full),
   .empty          (empty),
   .pop            (pop),
   .rsp_pwm_sample (rsp_pwm_sample),
   .rsp_channel    (rsp_channel),
   .rsp_chunk_end  (rsp_chunk_end)
);
